// ===== hw/rtl/rcls_pkg.sv =====
// shared types, constants and helper functions of the rotor cipher letter step block
// no dependencies; imported by every module of the block except rcls_ram
package rcls_pkg;

    localparam int NUM_WHEEL_TYPES = 5;
    localparam int MAX_PLUG_PAIRS  = 6;
    localparam int LETTERS         = 26;
    localparam int LETTER_W        = 5;
    localparam int ROW_W           = LETTERS * LETTER_W;
    localparam int ROW_DEPTH       = NUM_WHEEL_TYPES + 1;
    localparam int ROW_AW          = $clog2(ROW_DEPTH);
    localparam int PLUG_W          = 60;
    localparam int APB_DW          = 64;
    localparam int APB_AW          = 6;
    localparam int STAGES          = 7;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [2:0]          t_choice;

    // input operation codes
    typedef enum logic [1:0] {
        OP_ENCIPHER = 2'd0,
        OP_WIRE     = 2'd1,
        OP_POSITION = 2'd2
    } t_op;

    // wiring row select of the reflector
    localparam logic [2:0] REFLECT_SELECT = 3'd5;

    // wheel slots for position writes
    typedef enum logic [2:0] {
        SLOT_FAST   = 3'd0,
        SLOT_MIDDLE = 3'd1,
        SLOT_SLOW   = 3'd2
    } t_slot;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FAST_CHOICE   = 3'd0,
        REG_MIDDLE_CHOICE = 3'd1,
        REG_SLOW_CHOICE   = 3'd2,
        REG_FAST_RING     = 3'd3,
        REG_MIDDLE_RING   = 3'd4,
        REG_SLOW_RING     = 3'd5,
        REG_PLUG_PAIRS    = 3'd6,
        REG_PLUG_COUNT    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_choice           fast_choice;
        t_choice           middle_choice;
        t_choice           slow_choice;
        t_letter           fast_ring;
        t_letter           middle_ring;
        t_letter           slow_ring;
        logic [PLUG_W-1:0] plug_pairs;
        logic [2:0]        plug_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        fast_choice:   3'd1,
        middle_choice: 3'd2,
        slow_choice:   3'd3,
        fast_ring:     5'd22,
        middle_ring:   5'd23,
        slow_ring:     5'd19,
        plug_pairs:    '0,
        plug_count:    3'd0
    };

    // wiring memory port request
    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [ROW_W-1:0]  wdata;
        logic [ROW_AW-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIRE_READ,
        ST_WIRE_WRITE,
        ST_RUN,
        ST_OUT
    } t_state;

    // notch letter of each wheel type (Q E V J Z)
    function automatic t_letter notch_of(input logic [2:0] wtype);
        t_letter n;
        case (wtype)
            3'd0: n = 5'd16;
            3'd1: n = 5'd4;
            3'd2: n = 5'd21;
            3'd3: n = 5'd9;
            default: n = 5'd25;
        endcase
        return n;
    endfunction

    // wheel choice clamped to the available types, returned as a row index
    function automatic logic [2:0] wheel_type(input t_choice choice);
        logic [2:0] t;
        if (choice == 3'd0) begin
            t = 3'd0;
        end else if (choice > 3'(NUM_WHEEL_TYPES)) begin
            t = 3'(NUM_WHEEL_TYPES - 1);
        end else begin
            t = choice - 3'd1;
        end
        return t;
    endfunction

    // reduce a value below twice the letter count
    function automatic t_letter mod26(input logic [5:0] v);
        t_letter r;
        if (v >= 6'(LETTERS)) begin
            r = 5'(v - 6'(LETTERS));
        end else begin
            r = v[4:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rcls_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
module rcls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rcls_regs.sv =====
// apb configuration registers: wheel choices, rings and plugboard
// depends on rcls_pkg
module rcls_regs
    import rcls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:3]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_FAST_CHOICE:   n_cfg.fast_choice   = pwdata[2:0];
                REG_MIDDLE_CHOICE: n_cfg.middle_choice = pwdata[2:0];
                REG_SLOW_CHOICE:   n_cfg.slow_choice   = pwdata[2:0];
                REG_FAST_RING:     n_cfg.fast_ring     = pwdata[4:0];
                REG_MIDDLE_RING:   n_cfg.middle_ring   = pwdata[4:0];
                REG_SLOW_RING:     n_cfg.slow_ring     = pwdata[4:0];
                REG_PLUG_PAIRS:    n_cfg.plug_pairs    = pwdata[PLUG_W-1:0];
                REG_PLUG_COUNT:    n_cfg.plug_count    = pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_FAST_CHOICE:   prdata = APB_DW'(r_cfg.fast_choice);
            REG_MIDDLE_CHOICE: prdata = APB_DW'(r_cfg.middle_choice);
            REG_SLOW_CHOICE:   prdata = APB_DW'(r_cfg.slow_choice);
            REG_FAST_RING:     prdata = APB_DW'(r_cfg.fast_ring);
            REG_MIDDLE_RING:   prdata = APB_DW'(r_cfg.middle_ring);
            REG_SLOW_RING:     prdata = APB_DW'(r_cfg.slow_ring);
            REG_PLUG_PAIRS:    prdata = APB_DW'(r_cfg.plug_pairs);
            REG_PLUG_COUNT:    prdata = APB_DW'(r_cfg.plug_count);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/rcls_ctrl.sv =====
// sequencer and letter datapath: stepping, plugboard, row lookups and inverse search
// depends on rcls_pkg; drives the wiring memory through a t_mem_req bundle
module rcls_ctrl
    import rcls_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [2:0]       i_table_select,
    input  t_letter          i_entry_index,
    input  t_letter          i_letter_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_letter          o_out_letter,
    output t_mem_req         o_mem,
    input  logic [ROW_W-1:0] i_mem_rdata
);

    // control state
    t_state            r_state, n_state;
    logic [2:0]        r_step, n_step;
    t_letter           r_fast_pos, n_fast_pos;
    t_letter           r_mid_pos, n_mid_pos;
    t_letter           r_slow_pos, n_slow_pos;
    logic              r_pending, n_pending;
    logic              r_out_valid, n_out_valid;
    // payload
    t_letter           r_c, n_c;
    t_letter           r_off [3];
    t_letter           n_off [3];
    logic [ROW_AW-1:0] r_row, n_row;
    t_letter           r_idx, n_idx;
    t_letter           r_val, n_val;
    t_letter           r_out_letter, n_out_letter;

    logic [2:0]        type_fast, type_mid, type_slow;
    t_letter           ring26 [3];
    t_letter           pos [3];
    t_letter           stepped_fast, stepped_mid;
    logic [2:0]        stage;
    t_letter           stage_off;
    t_letter           shifted;
    t_letter           lookup, found;
    t_mem_req          mem;

    function automatic t_letter advance(input t_letter p);
        t_letter r;
        if (p == 5'(LETTERS - 1)) begin
            r = '0;
        end else begin
            r = p + 5'd1;
        end
        return r;
    endfunction

    // sequential pair swaps, pairs with an out-of-range letter are skipped
    function automatic t_letter plugboard(input t_letter c, input logic [PLUG_W-1:0] pairs,
                                          input logic [2:0] cnt);
        logic [2:0] n;
        t_letter    a;
        t_letter    b;
        t_letter    r;
        n = (cnt > 3'(MAX_PLUG_PAIRS)) ? 3'(MAX_PLUG_PAIRS) : cnt;
        r = c;
        for (int k = 0; k < MAX_PLUG_PAIRS; k++) begin
            a = pairs[10*k +: LETTER_W];
            b = pairs[10*k + LETTER_W +: LETTER_W];
            if (3'(k) < n && a < 5'(LETTERS) && b < 5'(LETTERS)) begin
                if (r == a) begin
                    r = b;
                end else if (r == b) begin
                    r = a;
                end
            end
        end
        return r;
    endfunction

    function automatic t_letter row_get(input logic [ROW_W-1:0] row, input t_letter idx);
        t_letter r;
        r = '0;
        for (int j = 0; j < LETTERS; j++) begin
            if (idx == 5'(j)) begin
                r = row[j*LETTER_W +: LETTER_W];
            end
        end
        return r;
    endfunction

    // lowest entry holding the letter, zero when none does
    function automatic t_letter row_find(input logic [ROW_W-1:0] row, input t_letter val);
        t_letter r;
        r = '0;
        for (int j = LETTERS - 1; j >= 0; j--) begin
            if (row[j*LETTER_W +: LETTER_W] == val) begin
                r = 5'(j);
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] row_put(input logic [ROW_W-1:0] row,
                                                 input t_letter idx, input t_letter val);
        logic [ROW_W-1:0] r;
        r = row;
        for (int j = 0; j < LETTERS; j++) begin
            if (idx == 5'(j)) begin
                r[j*LETTER_W +: LETTER_W] = val;
            end
        end
        return r;
    endfunction

    // row read order: three wheels forward, reflector, three wheels back
    function automatic logic [ROW_AW-1:0] seq_row(input logic [2:0] step, input logic [2:0] t0,
                                                  input logic [2:0] t1, input logic [2:0] t2);
        logic [2:0] r;
        case (step)
            3'd0: r = t0;
            3'd1: r = t1;
            3'd2: r = t2;
            3'd3: r = 3'(NUM_WHEEL_TYPES);
            3'd4: r = t2;
            3'd5: r = t1;
            default: r = t0;
        endcase
        return ROW_AW'(r);
    endfunction

    // slot types and ring offsets
    assign type_fast = wheel_type(i_cfg.fast_choice);
    assign type_mid  = wheel_type(i_cfg.middle_choice);
    assign type_slow = wheel_type(i_cfg.slow_choice);
    assign ring26[0] = mod26({1'b0, i_cfg.fast_ring});
    assign ring26[1] = mod26({1'b0, i_cfg.middle_ring});
    assign ring26[2] = mod26({1'b0, i_cfg.slow_ring});
    assign pos[0]    = r_fast_pos;
    assign pos[1]    = r_mid_pos;
    assign pos[2]    = r_slow_pos;

    // stepping ahead of a letter
    assign stepped_fast = advance(r_fast_pos);
    assign stepped_mid  = advance(r_mid_pos);

    // lookup stage working on the row read last cycle
    assign stage = r_step - 3'd1;
    always_comb begin
        case (stage)
            3'd0, 3'd6: stage_off = r_off[0];
            3'd1, 3'd5: stage_off = r_off[1];
            default:    stage_off = r_off[2];
        endcase
    end
    assign shifted = mod26({1'b0, r_c} + {1'b0, stage_off});
    assign lookup  = row_get(i_mem_rdata, (stage == 3'd3) ? r_c : shifted);
    assign found   = row_find(i_mem_rdata, shifted);

    // next state and outputs
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_fast_pos   = r_fast_pos;
        n_mid_pos    = r_mid_pos;
        n_slow_pos   = r_slow_pos;
        n_pending    = r_pending;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_c          = r_c;
        n_off        = r_off;
        n_row        = r_row;
        n_idx        = r_idx;
        n_val        = r_val;
        n_out_letter = r_out_letter;
        mem.we       = 1'b0;
        mem.waddr    = r_row;
        mem.wdata    = row_put(i_mem_rdata, r_idx, r_val);
        mem.raddr    = r_row;
        o_in_ready   = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        OP_WIRE: begin
                            if ((i_table_select < 3'(NUM_WHEEL_TYPES) ||
                                 i_table_select == REFLECT_SELECT) &&
                                i_entry_index < 5'(LETTERS)) begin
                                n_row   = (i_table_select == REFLECT_SELECT) ?
                                          ROW_AW'(NUM_WHEEL_TYPES) : ROW_AW'(i_table_select);
                                n_idx   = i_entry_index;
                                n_val   = mod26({1'b0, i_letter_value});
                                n_state = ST_WIRE_READ;
                            end
                        end
                        OP_POSITION: begin
                            case (i_table_select)
                                SLOT_FAST: begin
                                    n_fast_pos = mod26({1'b0, i_letter_value});
                                    n_pending  = 1'b0;
                                end
                                SLOT_MIDDLE: begin
                                    n_mid_pos = mod26({1'b0, i_letter_value});
                                    n_pending = 1'b0;
                                end
                                SLOT_SLOW: begin
                                    n_slow_pos = mod26({1'b0, i_letter_value});
                                    n_pending  = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                        OP_ENCIPHER: begin
                            if (i_letter_value < 5'(LETTERS)) begin
                                n_fast_pos = stepped_fast;
                                n_pending  = 1'b0;
                                if (r_pending) begin
                                    n_slow_pos = advance(r_slow_pos);
                                end
                                if (stepped_fast == notch_of(type_fast)) begin
                                    n_mid_pos = stepped_mid;
                                    if (stepped_mid == notch_of(type_mid)) begin
                                        n_pending = 1'b1;
                                    end
                                end
                                n_c     = plugboard(i_letter_value, i_cfg.plug_pairs,
                                                    i_cfg.plug_count);
                                n_step  = '0;
                                n_state = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_WIRE_READ: begin
                n_state = ST_WIRE_WRITE;
            end

            // row read back last cycle, write it with one entry replaced
            ST_WIRE_WRITE: begin
                mem.we  = 1'b1;
                n_state = ST_IDLE;
            end

            ST_RUN: begin
                mem.raddr = seq_row(r_step, type_fast, type_mid, type_slow);
                if (r_step == 3'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_off[i] = mod26({1'b0, pos[i]} + 6'(LETTERS) - {1'b0, ring26[i]});
                    end
                end else if (stage < 3'd3) begin
                    n_c = mod26({1'b0, lookup} + 6'(LETTERS) - {1'b0, stage_off});
                end else if (stage == 3'd3) begin
                    n_c = lookup;
                end else begin
                    n_c = mod26({1'b0, found} + 6'(LETTERS) - {1'b0, stage_off});
                end
                if (r_step == 3'(STAGES)) begin
                    n_state = ST_OUT;
                end
                n_step = r_step + 3'd1;
            end

            // final plugboard pass into the output register
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = plugboard(r_c, i_cfg.plug_pairs, i_cfg.plug_count);
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_fast_pos  <= '0;
            r_mid_pos   <= '0;
            r_slow_pos  <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_fast_pos  <= n_fast_pos;
            r_mid_pos   <= n_mid_pos;
            r_slow_pos  <= n_slow_pos;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c          <= n_c;
        r_off        <= n_off;
        r_row        <= n_row;
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_out_letter <= n_out_letter;
    end

    assign o_mem        = mem;
    assign o_out_valid  = r_out_valid;
    assign o_out_letter = r_out_letter;

endmodule

// ===== hw/rtl/rotor_cipher_letter_step_top.sv =====
// top level of the three-wheel rotor cipher letter step
// depends on rcls_pkg, rcls_ram, rcls_regs and rcls_ctrl
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_ready   i_operation, i_table_select,
//                                                i_entry_index, i_letter_value
// output    out        o_out_valid / i_out_ready o_out_letter
// config    in         apb psel/penable/pready   paddr, pwdata, prdata (64 bit)
//
// a letter holds the input side from transfer to next transfer: the transfer cycle steps the
// wheels and runs the plugboard, the run state streams the seven wiring row reads through
// the single read port, and the output state runs the final plugboard pass
// its result is registered in the output register by the final plugboard pass
// a wiring write reads the row and writes it back modified; a position write needs no memory
// access; reset is synchronous; the wiring memory has no reset and needs no clearing pass
// a stalled result waits in the output register; the next letter waits in its last cycle
module rotor_cipher_letter_step_top
    import rcls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_table_select,
    input  logic [4:0]        i_entry_index,
    input  logic [4:0]        i_letter_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [4:0]        o_out_letter,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg             cfg;
    t_mem_req         mem;
    logic [ROW_W-1:0] mem_rdata;

    // configuration registers
    rcls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer and datapath
    rcls_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_table_select (i_table_select),
        .i_entry_index  (i_entry_index),
        .i_letter_value (i_letter_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_letter   (o_out_letter),
        .o_mem          (mem),
        .i_mem_rdata    (mem_rdata)
    );

    // wiring rows, one full row of letters per word
    rcls_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_DEPTH)
    ) u_wiring (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== hw/rtl/rcls_checker.sv =====
// port-level assertions for the rotor cipher letter step top level, bound to it
// depends on rcls_pkg and rotor_cipher_letter_step_top
module rcls_checker
    import rcls_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_operation,
    input logic [4:0] i_letter_value,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [4:0] o_out_letter
);

    logic enc_xfer;

    assign enc_xfer = i_in_valid && o_in_ready && i_operation == OP_ENCIPHER &&
                      i_letter_value < 5'(LETTERS);

    // a stalled result holds its letter
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_letter))
        else $error("result changed while stalled");

    // a letter transfer keeps the input side busy as the row reads begin
    a_letter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enc_xfer |=> !o_in_ready ##1 !o_in_ready)
        else $error("input ready during letter processing");

    // only letters produce results
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_operation != OP_ENCIPHER && !o_out_valid
        |=> !o_out_valid)
        else $error("result without a letter");

    // a new result appears only at the end of letter processing
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised while idle");

endmodule

bind rotor_cipher_letter_step_top rcls_checker u_rcls_checker (.*);
